// ===== sv/tpf_pkg.sv =====
// Package: shared types, constants and helpers of the text page formatter.
`timescale 1ns / 1ps

package tpf_pkg;

  // Limits on the effective register values
  localparam logic [4:0] MARGIN_MAX = 5'd16;
  localparam logic [3:0] TAB_MIN    = 4'd2;
  localparam logic [3:0] TAB_MAX    = 4'd8;

  // Register reset values
  localparam logic [6:0] LPP_RESET    = 7'd75;
  localparam logic [3:0] TAB_RESET    = 4'd8;
  localparam logic [4:0] MARGIN_RESET = 5'd0;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_LINES_PER_PAGE = 2'd0;
  localparam logic [1:0] CFG_TAB_WIDTH      = 2'd1;
  localparam logic [1:0] CFG_LEFT_MARGIN    = 2'd2;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Input kind codes
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  // Page eject sequence: CR ESC & l 0 H
  localparam logic [4:0] EJECT_LEN = 5'd6;

  function automatic logic [7:0] eject_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h0D;
      3'd1:    b = 8'h1B;
      3'd2:    b = 8'h26;
      3'd3:    b = 8'h6C;
      3'd4:    b = 8'h30;
      3'd5:    b = 8'h48;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Phase modulo the tab width; the phase is below 8 and the width at least 2
  function automatic logic [2:0] phase_mod(input logic [2:0] p, input logic [3:0] w);
    logic [3:0] r;
    r = {1'b0, p};
    for (int i = 0; i < 3; i++) begin
      if (r >= w) r = r - w;
    end
    return r[2:0];
  endfunction

  // Class of the item seen on the input channel
  typedef enum logic [2:0] {
    CLS_EOF,
    CLS_FF,
    CLS_NL,
    CLS_CR,
    CLS_TAB,
    CLS_CHAR
  } cls_t;

  // Run counter load sources
  typedef enum logic [1:0] {
    LD_NONE,
    LD_MARGIN,
    LD_TAB,
    LD_EJECT
  } load_t;

  // Output byte sources
  typedef enum logic [2:0] {
    SEL_SPACE,
    SEL_CHAR,
    SEL_EJECT,
    SEL_CR,
    SEL_LF
  } sel_t;

  // Datapath status toward the controller
  typedef struct packed {
    cls_t cls;          // class of the item on the input channel
    logic eof_pending;  // lines counted on the current page
    logic nl_eject;     // a newline now reaches the page length
    logic need_margin;  // at line start with a nonzero margin
    logic cnt_one;      // run counter on its final byte
    logic can_emit;     // output register free this cycle
  } stat_t;

  // Controller commands toward the datapath
  typedef struct packed {
    logic  take;   // accept the input item and update line state
    load_t load;   // load the run counter
    logic  dec;    // count one byte of the run
    logic  emit;   // write a byte into the output register
    sel_t  sel;    // which byte
    logic  last;   // final byte of this item
  } cmd_t;

endpackage

// ===== sv/tpf_datapath.sv =====
// Datapath: configuration registers, line state, run counter and output register.
`timescale 1ns / 1ps

module tpf_datapath (
  input  logic                clk,
  input  logic                rst_n,
  // input item fields
  input  logic [7:0]          in_tdata,   // text_byte
  input  logic                in_tuser,   // kind
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_data,
  // result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // out_byte
  output logic                out_tlast,  // last
  // controller link
  input  tpf_pkg::cmd_t       cmd,
  output tpf_pkg::stat_t      stat
);

  logic [6:0] lpp_r;
  logic [3:0] tab_width_r;
  logic [4:0] margin_r;

  logic       at_line_start_r;
  logic [2:0] tab_phase_r;
  logic [6:0] line_count_r;

  logic [7:0] char_r;
  logic [3:0] tab_run_r;
  logic [4:0] cnt_r;

  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_last_r;

  logic [3:0] tw;
  logic [4:0] margin_eff;
  logic [2:0] ph;
  logic [3:0] ph_inc;
  logic [3:0] tab_run;
  logic [7:0] line_inc;
  logic       nl_eject;
  logic [4:0] eject_pos;
  logic [7:0] byte_sel;
  tpf_pkg::cls_t cls;

  // Effective register values; lines per page cannot exceed its 127 ceiling
  always_comb begin
    if (tab_width_r < tpf_pkg::TAB_MIN)      tw = tpf_pkg::TAB_MIN;
    else if (tab_width_r > tpf_pkg::TAB_MAX) tw = tpf_pkg::TAB_MAX;
    else                                     tw = tab_width_r;
    margin_eff = (margin_r > tpf_pkg::MARGIN_MAX) ? tpf_pkg::MARGIN_MAX : margin_r;
  end

  assign ph       = tpf_pkg::phase_mod(tab_phase_r, tw);
  assign ph_inc   = {1'b0, ph} + 4'd1;
  assign tab_run  = tw - {1'b0, ph};
  assign line_inc = {1'b0, line_count_r} + 8'd1;
  assign nl_eject = (line_inc >= {1'b0, lpp_r});

  // Classify the item on the input channel
  always_comb begin
    if (in_tuser == tpf_pkg::KIND_EOF) begin
      cls = tpf_pkg::CLS_EOF;
    end else begin
      case (in_tdata)
        tpf_pkg::CH_FF:  cls = tpf_pkg::CLS_FF;
        tpf_pkg::CH_LF:  cls = tpf_pkg::CLS_NL;
        tpf_pkg::CH_CR:  cls = tpf_pkg::CLS_CR;
        tpf_pkg::CH_TAB: cls = tpf_pkg::CLS_TAB;
        default:         cls = tpf_pkg::CLS_CHAR;
      endcase
    end
  end

  // Status toward the controller
  assign stat.cls         = cls;
  assign stat.eof_pending = (line_count_r != 7'd0);
  assign stat.nl_eject    = nl_eject;
  assign stat.need_margin = at_line_start_r && (margin_eff != 5'd0);
  assign stat.cnt_one     = (cnt_r == 5'd1);
  assign stat.can_emit    = !out_valid_r || out_tready;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpp_r       <= tpf_pkg::LPP_RESET;
      tab_width_r <= tpf_pkg::TAB_RESET;
      margin_r    <= tpf_pkg::MARGIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tpf_pkg::CFG_LINES_PER_PAGE: lpp_r       <= cfg_data;
        tpf_pkg::CFG_TAB_WIDTH:      tab_width_r <= cfg_data[3:0];
        tpf_pkg::CFG_LEFT_MARGIN:    margin_r    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Line state, updated when an item is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_line_start_r <= 1'b1;
      tab_phase_r     <= 3'd0;
      line_count_r    <= 7'd0;
    end else if (cmd.take) begin
      case (cls)
        tpf_pkg::CLS_EOF, tpf_pkg::CLS_FF: begin
          at_line_start_r <= 1'b1;
          tab_phase_r     <= 3'd0;
          line_count_r    <= 7'd0;
        end
        tpf_pkg::CLS_NL: begin
          at_line_start_r <= 1'b1;
          tab_phase_r     <= 3'd0;
          line_count_r    <= nl_eject ? 7'd0 : line_inc[6:0];
        end
        tpf_pkg::CLS_CR: begin
          at_line_start_r <= 1'b1;
          tab_phase_r     <= 3'd0;
        end
        tpf_pkg::CLS_TAB: begin
          at_line_start_r <= 1'b0;
          tab_phase_r     <= 3'd0;
        end
        default: begin
          at_line_start_r <= 1'b0;
          tab_phase_r     <= (ph_inc == tw) ? 3'd0 : ph_inc[2:0];
        end
      endcase
    end
  end

  // Item payload kept for the byte runs
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      char_r    <= in_tdata;
      tab_run_r <= tab_run;
    end
  end

  // Run counter: bytes left in the margin, tab or eject run
  // (a tab with no margin loads its run in the same cycle the item is taken)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 5'd0;
    end else begin
      case (cmd.load)
        tpf_pkg::LD_MARGIN: cnt_r <= margin_eff;
        tpf_pkg::LD_TAB:    cnt_r <= {1'b0, (cmd.take ? tab_run : tab_run_r)};
        tpf_pkg::LD_EJECT:  cnt_r <= tpf_pkg::EJECT_LEN;
        default: if (cmd.dec) cnt_r <= cnt_r - 5'd1;
      endcase
    end
  end

  // Output byte selection
  assign eject_pos = tpf_pkg::EJECT_LEN - cnt_r;

  always_comb begin
    case (cmd.sel)
      tpf_pkg::SEL_CHAR:  byte_sel = char_r;
      tpf_pkg::SEL_EJECT: byte_sel = tpf_pkg::eject_byte(eject_pos[2:0]);
      tpf_pkg::SEL_CR:    byte_sel = tpf_pkg::CH_CR;
      tpf_pkg::SEL_LF:    byte_sel = tpf_pkg::CH_LF;
      default:            byte_sel = tpf_pkg::CH_SPACE;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= byte_sel;
      out_last_r <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== sv/tpf_ctrl.sv =====
// Controller: sequences the output bytes that one input item causes.
`timescale 1ns / 1ps

module tpf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  tpf_pkg::stat_t stat,
  output tpf_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MARGIN_TAB,
    S_MARGIN_CHAR,
    S_TAB,
    S_CHAR,
    S_EJECT,
    S_CR,
    S_CRLF_CR,
    S_CRLF_LF
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.take  = 1'b0;
    cmd.load  = tpf_pkg::LD_NONE;
    cmd.dec   = 1'b0;
    cmd.emit  = 1'b0;
    cmd.sel   = tpf_pkg::SEL_SPACE;
    cmd.last  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.take = 1'b1;
          case (stat.cls)
            tpf_pkg::CLS_EOF: begin
              if (stat.eof_pending) begin
                cmd.load  = tpf_pkg::LD_EJECT;
                state_nxt = S_EJECT;
              end
            end
            tpf_pkg::CLS_FF: begin
              cmd.load  = tpf_pkg::LD_EJECT;
              state_nxt = S_EJECT;
            end
            tpf_pkg::CLS_NL: begin
              if (stat.nl_eject) begin
                cmd.load  = tpf_pkg::LD_EJECT;
                state_nxt = S_EJECT;
              end else begin
                state_nxt = S_CRLF_CR;
              end
            end
            tpf_pkg::CLS_CR: state_nxt = S_CR;
            tpf_pkg::CLS_TAB: begin
              if (stat.need_margin) begin
                cmd.load  = tpf_pkg::LD_MARGIN;
                state_nxt = S_MARGIN_TAB;
              end else begin
                cmd.load  = tpf_pkg::LD_TAB;
                state_nxt = S_TAB;
              end
            end
            default: begin
              if (stat.need_margin) begin
                cmd.load  = tpf_pkg::LD_MARGIN;
                state_nxt = S_MARGIN_CHAR;
              end else begin
                state_nxt = S_CHAR;
              end
            end
          endcase
        end
      end
      S_MARGIN_TAB: begin
        if (stat.can_emit) begin
          cmd.emit = 1'b1;
          cmd.dec  = 1'b1;
          if (stat.cnt_one) begin
            cmd.load  = tpf_pkg::LD_TAB;
            state_nxt = S_TAB;
          end
        end
      end
      S_MARGIN_CHAR: begin
        if (stat.can_emit) begin
          cmd.emit = 1'b1;
          cmd.dec  = 1'b1;
          if (stat.cnt_one) state_nxt = S_CHAR;
        end
      end
      S_TAB: begin
        if (stat.can_emit) begin
          cmd.emit = 1'b1;
          cmd.dec  = 1'b1;
          cmd.last = stat.cnt_one;
          if (stat.cnt_one) state_nxt = S_IDLE;
        end
      end
      S_CHAR: begin
        cmd.sel = tpf_pkg::SEL_CHAR;
        if (stat.can_emit) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EJECT: begin
        cmd.sel = tpf_pkg::SEL_EJECT;
        if (stat.can_emit) begin
          cmd.emit = 1'b1;
          cmd.dec  = 1'b1;
          cmd.last = stat.cnt_one;
          if (stat.cnt_one) state_nxt = S_IDLE;
        end
      end
      S_CR: begin
        cmd.sel = tpf_pkg::SEL_CR;
        if (stat.can_emit) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CRLF_CR: begin
        cmd.sel = tpf_pkg::SEL_CR;
        if (stat.can_emit) begin
          cmd.emit  = 1'b1;
          state_nxt = S_CRLF_LF;
        end
      end
      S_CRLF_LF: begin
        cmd.sel = tpf_pkg::SEL_LF;
        if (stat.can_emit) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/text_page_formatter.sv =====
// Top level: text page formatter, controller plus datapath.
//
// Takes text bytes (or an end-of-file mark) on the in_ stream and sends printer
// bytes on the out_ stream. in_tuser is the kind (0 text, 1 end of file), in_tdata
// the character. out_tlast marks the final byte that one input item causes.
// Lines get the left margin in blanks, tabs expand to the next stop, newline
// becomes CR LF or the page eject sequence, form feed ejects the page.
// Registers are written on the cfg_ port (index 0 lines per page, 1 tab width,
// 2 left margin) by the user, and only while no item is in progress; the block
// itself does not enforce this. cfg_ready is always high. An item is taken only
// when the previous one has issued all its bytes. The item is accepted first,
// then its bytes are written into the output register one after another. An
// end of file with no lines pending gives no bytes. When the receiver stalls,
// the byte waits in the output register and the sequencer holds until it is
// taken. Reset (synchronous, rst_n low) clears the output register and line
// state and restores the register defaults.
`timescale 1ns / 1ps

module text_page_formatter (
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tuser,   // [0] kind
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  tpf_pkg::cmd_t  cmd;
  tpf_pkg::stat_t stat;

  tpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tpf_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ===== sv/tpf_checker.sv =====
// Checker: port-level assertions for the text page formatter, bound to the top.
`timescale 1ns / 1ps

module tpf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A text byte always causes output, so the block is busy after taking one
  a_text_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> !in_tready)
    else $error("input ready right after a text byte");

  // No new item while the current one still has bytes to send
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready in the middle of a run");

  // A run continues without a gap once a non-final byte is taken
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a run");

endmodule

bind text_page_formatter tpf_checker u_tpf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== bench/text_page_formatter_tb.sv =====
// Testbench for text_page_formatter: queued stimulus, predicted printer bytes, stream checks.
`timescale 1ns / 1ps

module text_page_formatter_tb;

  // Eject sequence CR ESC & l 0 H, first byte in the low bits
  localparam logic [47:0] EJECT_SEQ = {8'h48, 8'h30, 8'h6C, 8'h26, 8'h1B, 8'h0D};
  localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int SETTLE       = 30;    // settle wait after the last byte
  localparam int RAND_PHASES  = 7;
  localparam int RAND_PER_PH  = 51;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
  } text_item_t;

  typedef struct packed {
    logic [7:0] pbyte;
    logic       last;
  } printer_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = tpf_pkg::CFG_LINES_PER_PAGE;
  logic [6:0] cfg_data = 7'd0;

  text_page_formatter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_item_t    text_q[$];     // items waiting to be sent
  printer_byte_t printer_q[$];  // bytes the printer should see, oldest first

  // Shadow of the registers and line state
  logic [6:0] lpp_reg;
  logic [3:0] tab_reg;
  logic [4:0] margin_reg;
  logic       line_start;
  logic [2:0] tab_phase;
  logic [6:0] line_count;

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  hold_asked = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  int  fails = 0;
  int  quiet_cycles = 0;
  logic in_fire = 1'b0;

  task automatic push_printer(input logic [7:0] b);
    printer_q.push_back('{pbyte: b, last: 1'b0});
  endtask

  task automatic push_eject();
    for (int i = 0; i < 6; i++) push_printer(EJECT_SEQ[8*i +: 8]);
  endtask

  task automatic push_margin();
    logic [4:0] m;
    m = (margin_reg > tpf_pkg::MARGIN_MAX) ? tpf_pkg::MARGIN_MAX : margin_reg;
    for (int i = 0; i < int'(m); i++) push_printer(tpf_pkg::CH_SPACE);
  endtask

  // Printer bytes caused by one accepted text item; updates the line state
  task automatic format_item(input logic kind, input logic [7:0] ch);
    logic [3:0]    tw;
    logic [2:0]    ph;
    logic [7:0]    n;
    int            start;
    printer_byte_t tail;
    start = printer_q.size();
    tw = (tab_reg < tpf_pkg::TAB_MIN) ? tpf_pkg::TAB_MIN :
         ((tab_reg > tpf_pkg::TAB_MAX) ? tpf_pkg::TAB_MAX : tab_reg);
    ph = 3'(int'(tab_phase) % int'(tw));
    if (kind == tpf_pkg::KIND_EOF) begin
      if (line_count != 7'd0) push_eject();
      line_start = 1'b1;
      tab_phase  = 3'd0;
      line_count = 7'd0;
    end else if (ch == tpf_pkg::CH_FF) begin
      push_eject();
      line_start = 1'b1;
      tab_phase  = 3'd0;
      line_count = 7'd0;
    end else if (ch == tpf_pkg::CH_LF) begin
      n = {1'b0, line_count} + 8'd1;
      if (n >= {1'b0, lpp_reg}) begin
        push_eject();
        line_count = 7'd0;
      end else begin
        push_printer(tpf_pkg::CH_CR);
        push_printer(tpf_pkg::CH_LF);
        line_count = n[6:0];
      end
      line_start = 1'b1;
      tab_phase  = 3'd0;
    end else if (ch == tpf_pkg::CH_CR) begin
      push_printer(tpf_pkg::CH_CR);
      line_start = 1'b1;
      tab_phase  = 3'd0;
    end else if (ch == tpf_pkg::CH_TAB) begin
      if (line_start) push_margin();
      for (int k = int'(tw) - int'(ph); k > 0; k--) push_printer(tpf_pkg::CH_SPACE);
      line_start = 1'b0;
      tab_phase  = 3'd0;
    end else begin
      if (line_start) push_margin();
      push_printer(ch);
      line_start = 1'b0;
      tab_phase  = 3'((int'(ph) + 1) % int'(tw));
    end
    // mark the final byte of this item
    if (printer_q.size() > start) begin
      tail = printer_q.pop_back();
      tail.last = 1'b1;
      printer_q.push_back(tail);
    end
  endtask

  // Sender: offers queued items, idling at random
  always @(negedge clk) begin
    text_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (text_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = text_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= it.ch;
        in_tuser  <= it.kind;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus the occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_served + 1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: predict on input transfers, check output transfers
  always @(posedge clk) begin
    printer_byte_t want;
    logic out_fire;
    in_fire  = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    if (in_fire) format_item(in_tuser, in_tdata);
    if (out_fire) begin
      if (printer_q.size() == 0) begin
        $error("out_byte: expected none, actual %h", out_tdata);
        fails++;
      end else begin
        want = printer_q.pop_front();
        if (out_tdata !== want.pbyte) begin
          $error("out_byte: expected %h, actual %h", want.pbyte, out_tdata);
          fails++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %b, actual %b", want.last, out_tlast);
          fails++;
        end
      end
    end
    if (in_fire || out_fire || (rst_n && cfg_valid && cfg_ready)) quiet_cycles = 0;
    else quiet_cycles++;
  end

  // Watchdog
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  task automatic add_item(input logic kind, input logic [7:0] ch);
    text_q.push_back('{kind: kind, ch: ch});
  endtask

  function automatic text_item_t random_text();
    text_item_t it;
    int r;
    r = $urandom_range(99);
    it.kind = tpf_pkg::KIND_TEXT;
    if (r < 50)      it.ch = 8'($urandom_range(8'h20, 8'h7E));
    else if (r < 62) it.ch = tpf_pkg::CH_TAB;
    else if (r < 74) it.ch = tpf_pkg::CH_LF;
    else if (r < 80) it.ch = tpf_pkg::CH_CR;
    else if (r < 83) it.ch = tpf_pkg::CH_FF;
    else if (r < 87) begin
      it.kind = tpf_pkg::KIND_EOF;
      it.ch = 8'($urandom_range(255));
    end else it.ch = 8'($urandom_range(255));
    return it;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tpf_pkg::CFG_LINES_PER_PAGE: lpp_reg = val;
      tpf_pkg::CFG_TAB_WIDTH:      tab_reg = val[3:0];
      tpf_pkg::CFG_LEFT_MARGIN:    margin_reg = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_layout(input logic [6:0] lpp, input logic [6:0] tw, input logic [6:0] lm);
    write_reg(tpf_pkg::CFG_LINES_PER_PAGE, lpp);
    write_reg(tpf_pkg::CFG_TAB_WIDTH, tw);
    write_reg(tpf_pkg::CFG_LEFT_MARGIN, lm);
  endtask

  // Wait until every queued item is sent and every byte has come out
  task automatic wait_page_done();
    do @(negedge clk); while (text_q.size() != 0 || in_tvalid || printer_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    lpp_reg    = tpf_pkg::LPP_RESET;
    tab_reg    = tpf_pkg::TAB_RESET;
    margin_reg = tpf_pkg::MARGIN_RESET;
    line_start = 1'b1;
    tab_phase  = 3'd0;
    line_count = 7'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset defaults, every character class, eof with and without lines
    add_item(tpf_pkg::KIND_TEXT, 8'h41);
    add_item(tpf_pkg::KIND_TEXT, tpf_pkg::CH_TAB);
    add_item(tpf_pkg::KIND_TEXT, tpf_pkg::CH_CR);
    add_item(tpf_pkg::KIND_TEXT, tpf_pkg::CH_TAB);
    add_item(tpf_pkg::KIND_TEXT, 8'h42);
    add_item(tpf_pkg::KIND_TEXT, tpf_pkg::CH_LF);
    add_item(tpf_pkg::KIND_TEXT, tpf_pkg::CH_FF);
    add_item(tpf_pkg::KIND_EOF,  8'h00);
    add_item(tpf_pkg::KIND_TEXT, 8'h7A);
    add_item(tpf_pkg::KIND_TEXT, tpf_pkg::CH_LF);
    add_item(tpf_pkg::KIND_EOF,  8'hFF);
    add_item(tpf_pkg::KIND_TEXT, 8'h00);
    add_item(tpf_pkg::KIND_TEXT, 8'hFF);
    wait_page_done();

    // Clamped extremes: widest margin, tab above max and below min, eject on every newline
    set_layout(7'd1, 7'd15, 7'd31);
    add_item(tpf_pkg::KIND_TEXT, tpf_pkg::CH_TAB);
    add_item(tpf_pkg::KIND_TEXT, 8'h71);
    add_item(tpf_pkg::KIND_TEXT, tpf_pkg::CH_LF);
    wait_page_done();
    set_layout(7'd0, 7'd0, 7'd16);
    add_item(tpf_pkg::KIND_TEXT, 8'h72);
    add_item(tpf_pkg::KIND_TEXT, tpf_pkg::CH_TAB);
    add_item(tpf_pkg::KIND_TEXT, tpf_pkg::CH_LF);
    wait_page_done();

    // Tab width changed mid-line, then page length lowered mid-page
    set_layout(7'd127, 7'd3, 7'd0);
    add_item(tpf_pkg::KIND_TEXT, 8'h61);
    add_item(tpf_pkg::KIND_TEXT, 8'h62);
    wait_page_done();
    write_reg(tpf_pkg::CFG_TAB_WIDTH, 7'd2);
    add_item(tpf_pkg::KIND_TEXT, tpf_pkg::CH_TAB);
    add_item(tpf_pkg::KIND_TEXT, tpf_pkg::CH_LF);
    add_item(tpf_pkg::KIND_TEXT, tpf_pkg::CH_LF);
    add_item(tpf_pkg::KIND_TEXT, tpf_pkg::CH_LF);
    wait_page_done();
    write_reg(tpf_pkg::CFG_LINES_PER_PAGE, 7'd2);
    add_item(tpf_pkg::KIND_TEXT, tpf_pkg::CH_LF);
    wait_page_done();

    // Random text under several layouts and flow-control patterns
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin set_layout(7'd20, 7'd8, 7'd0);   send_idle_pct = 0;  stall_pct = 0;  end
        1: begin set_layout(7'd90, 7'd2, 7'd16);  send_idle_pct = 63; stall_pct = 0;  end
        2: begin set_layout(7'd127, 7'd4, 7'd3);  send_idle_pct = 0;  stall_pct = 63; end
        3: begin set_layout(7'd0, 7'd7, 7'd31);   send_idle_pct = 22; stall_pct = 22; end
        4: begin set_layout(7'd3, 7'd5, 7'd2);    send_idle_pct = 0;  stall_pct = 0;  end
        5: begin
          set_layout(7'($urandom_range(20, 90)), 7'($urandom_range(15)),
                     7'($urandom_range(31)));
          send_idle_pct = 22;
          stall_pct = 22;
        end
        default: begin set_layout(7'd1, 7'd6, 7'd9); send_idle_pct = 63; stall_pct = 63; end
      endcase
      for (int i = 0; i < RAND_PER_PH; i++) text_q.push_back(random_text());
      // receiver holds off while the sender keeps offering
      if (p == 4) hold_asked++;
      wait_page_done();
    end

    if (fails == 0 && printer_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
